// ===== src/tic_pkg.sv =====
// Shared constants and types for the triangle index compactor.
package tic_pkg;

	localparam int MAX_VERTICES = 65536;
	localparam int VIDX_W       = $clog2(MAX_VERTICES);
	localparam int CNT_W        = VIDX_W + 1;
	localparam int IDX_W        = 24;
	localparam int CORNER_W     = 32;

	localparam logic [IDX_W-1:0] INDEX_SAT = '1;
	localparam logic [CNT_W-1:0] LIMIT_MAX = CNT_W'(MAX_VERTICES);

	localparam logic KIND_CORNER  = 1'b0;
	localparam logic KIND_SUMMARY = 1'b1;

	typedef struct packed {
		logic              map_rd;
		logic              inv_rd;
		logic              wr;
		logic [VIDX_W-1:0] vtx;
	} map_cmd_t;

	typedef struct packed {
		logic              hit;
		logic [VIDX_W-1:0] compact;
	} map_rsp_t;

	typedef struct packed {
		logic              record_kind;
		logic [15:0]       compact_index;
		logic              new_vertex;
		logic [15:0]       source_vertex;
		logic [CNT_W-1:0]  vertex_total;
		logic [IDX_W-1:0]  index_total;
		logic              empty_mesh;
		logic              last_of_run;
	} rec_t;

endpackage

// ===== src/tic_req_if.sv =====
// Request channel carrying one triangle.
interface tic_req_if;
	import tic_pkg::*;

	logic                valid;
	logic                ready;
	logic                new_mesh;
	logic [CORNER_W-1:0] corner_a;
	logic [CORNER_W-1:0] corner_b;
	logic [CORNER_W-1:0] corner_c;
	logic                last_triangle;

	modport source (output valid, new_mesh, corner_a, corner_b, corner_c, last_triangle,
		input ready);
	modport sink (input valid, new_mesh, corner_a, corner_b, corner_c, last_triangle,
		output ready);
endinterface

// ===== src/tic_res_if.sv =====
// Result channel carrying one corner or summary record.
interface tic_res_if;
	import tic_pkg::*;

	logic              valid;
	logic              ready;
	logic              record_kind;
	logic [15:0]       compact_index;
	logic              new_vertex;
	logic [15:0]       source_vertex;
	logic [CNT_W-1:0]  vertex_total;
	logic [IDX_W-1:0]  index_total;
	logic              empty_mesh;
	logic              last_of_run;

	modport source (output valid, record_kind, compact_index, new_vertex, source_vertex,
		vertex_total, index_total, empty_mesh, last_of_run, input ready);
	modport sink (input valid, record_kind, compact_index, new_vertex, source_vertex,
		vertex_total, index_total, empty_mesh, last_of_run, output ready);
endinterface

// ===== src/tic_map_store.sv =====
// Remap RAM plus back-pointer RAM; a vertex is mapped when both agree and its slot is below next_compact.
module tic_map_store (
	input  logic                           clk,
	input  tic_pkg::map_cmd_t              cmd,
	input  logic [tic_pkg::CNT_W-1:0]      next_compact,
	output tic_pkg::map_rsp_t              rsp
);
	import tic_pkg::*;

	logic [VIDX_W-1:0] remap_mem [MAX_VERTICES];
	logic [VIDX_W-1:0] inv_mem   [MAX_VERTICES];
	logic [VIDX_W-1:0] remap_q;
	logic [VIDX_W-1:0] inv_q;

	always_ff @(posedge clk) begin
		if (cmd.wr)
			remap_mem[cmd.vtx] <= next_compact[VIDX_W-1:0];
		if (cmd.map_rd)
			remap_q <= remap_mem[cmd.vtx];
	end

	always_ff @(posedge clk) begin
		if (cmd.wr)
			inv_mem[next_compact[VIDX_W-1:0]] <= cmd.vtx;
		if (cmd.inv_rd)
			inv_q <= inv_mem[remap_q];
	end

	// live only if the slot was handed out in this mesh and points back here
	always_comb begin
		if (({1'b0, remap_q} < next_compact) && (inv_q == cmd.vtx))
			rsp.hit = 1'b1;
		else
			rsp.hit = 1'b0;
		rsp.compact = remap_q;
	end
endmodule

// ===== src/triangle_index_compactor_core.sv =====
// Triangle index compactor: sequencer, counters, result register and checks.
// One triangle is taken per request while idle. Its corners are checked one per
// cycle for range and pairwise inequality. Each corner of a kept triangle then
// takes these steps on the shared map store: read the remap RAM, read the
// back-pointer RAM at that slot, then decide, write on first use and load the
// result register. A stalled result register holds the decide and summary steps
// until it is free.
// Mesh clearing is immediate: a remap entry counts only if its slot is below the
// vertex counter and the back-pointer names the same vertex, so no clearing pass
// runs after reset or at a new mesh.
module triangle_index_compactor_core (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_wr_en,
	input  logic [tic_pkg::CNT_W-1:0] cfg_wr_data,
	tic_req_if.sink                   req,
	tic_res_if.source                 res
);
	import tic_pkg::*;

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_CHK    = 3'd1;
	localparam logic [2:0] S_RD_MAP = 3'd2;
	localparam logic [2:0] S_RD_INV = 3'd3;
	localparam logic [2:0] S_DEC    = 3'd4;
	localparam logic [2:0] S_SUM    = 3'd5;

	localparam logic [1:0] LAST_CORNER = 2'd2;

	logic [2:0]          state_q;
	logic [1:0]          sel_q;
	logic                keep_q;
	logic                last_q;
	logic [CORNER_W-1:0] corner0_q, corner1_q, corner2_q;
	logic [CNT_W-1:0]    limit_q;
	logic [CNT_W-1:0]    next_q;
	logic [IDX_W-1:0]    emit_q;
	logic                out_valid_q;
	rec_t                rec_q;

	map_cmd_t            cmd;
	map_rsp_t            rsp;
	logic                slot_free;
	logic                load_rec;
	logic                corner_ok;
	logic [VIDX_W-1:0]   vtx;

	assign slot_free = !out_valid_q || res.ready;
	assign load_rec  = slot_free && ((state_q == S_DEC) || (state_q == S_SUM));
	assign vtx       = corner0_q[VIDX_W-1:0];
	assign corner_ok = (corner0_q < CORNER_W'(limit_q)) && (corner0_q != corner1_q);

	always_comb begin
		cmd.map_rd = (state_q == S_RD_MAP);
		cmd.inv_rd = (state_q == S_RD_INV);
		cmd.wr     = (state_q == S_DEC) && slot_free && !rsp.hit;
		cmd.vtx    = vtx;
	end

	tic_map_store u_store (
		.clk          (clk),
		.cmd          (cmd),
		.next_compact (next_q),
		.rsp          (rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_MAX;
		end else if (cfg_wr_en) begin
			limit_q <= (cfg_wr_data > LIMIT_MAX) ? LIMIT_MAX : cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			sel_q       <= '0;
			keep_q      <= 1'b0;
			last_q      <= 1'b0;
			corner0_q   <= '0;
			corner1_q   <= '0;
			corner2_q   <= '0;
			next_q      <= '0;
			emit_q      <= '0;
			out_valid_q <= 1'b0;
			rec_q       <= '0;
		end else begin
			if (load_rec)
				out_valid_q <= 1'b1;
			else if (res.ready)
				out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						corner0_q <= req.corner_a;
						corner1_q <= req.corner_b;
						corner2_q <= req.corner_c;
						last_q    <= req.last_triangle;
						keep_q    <= 1'b1;
						sel_q     <= '0;
						if (req.new_mesh) begin
							next_q <= '0;
							emit_q <= '0;
						end
						state_q <= S_CHK;
					end
				end
				S_CHK: begin
					corner0_q <= corner1_q;
					corner1_q <= corner2_q;
					corner2_q <= corner0_q;
					if (!corner_ok)
						keep_q <= 1'b0;
					if (sel_q == LAST_CORNER) begin
						sel_q <= '0;
						if (keep_q && corner_ok)
							state_q <= S_RD_MAP;
						else if (last_q)
							state_q <= S_SUM;
						else
							state_q <= S_IDLE;
					end else begin
						sel_q <= sel_q + 2'd1;
					end
				end
				S_RD_MAP: state_q <= S_RD_INV;
				S_RD_INV: state_q <= S_DEC;
				S_DEC: begin
					if (slot_free) begin
						rec_q.record_kind   <= KIND_CORNER;
						rec_q.source_vertex <= 16'(vtx);
						rec_q.vertex_total  <= '0;
						rec_q.index_total   <= '0;
						rec_q.empty_mesh    <= 1'b0;
						rec_q.last_of_run   <= (sel_q == LAST_CORNER) && !last_q;
						if (rsp.hit) begin
							rec_q.compact_index <= 16'(rsp.compact);
							rec_q.new_vertex    <= 1'b0;
						end else begin
							rec_q.compact_index <= 16'(next_q[VIDX_W-1:0]);
							rec_q.new_vertex    <= 1'b1;
							next_q              <= next_q + CNT_W'(1);
						end
						if (emit_q != INDEX_SAT)
							emit_q <= emit_q + IDX_W'(1);
						corner0_q <= corner1_q;
						corner1_q <= corner2_q;
						corner2_q <= corner0_q;
						if (sel_q == LAST_CORNER) begin
							sel_q   <= '0;
							state_q <= last_q ? S_SUM : S_IDLE;
						end else begin
							sel_q   <= sel_q + 2'd1;
							state_q <= S_RD_MAP;
						end
					end
				end
				S_SUM: begin
					if (slot_free) begin
						rec_q.record_kind   <= KIND_SUMMARY;
						rec_q.compact_index <= '0;
						rec_q.new_vertex    <= 1'b0;
						rec_q.source_vertex <= '0;
						rec_q.vertex_total  <= next_q;
						rec_q.index_total   <= emit_q;
						rec_q.empty_mesh    <= (emit_q == '0);
						rec_q.last_of_run   <= 1'b1;
						state_q             <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign req.ready         = (state_q == S_IDLE);
	assign res.valid         = out_valid_q;
	assign res.record_kind   = rec_q.record_kind;
	assign res.compact_index = rec_q.compact_index;
	assign res.new_vertex    = rec_q.new_vertex;
	assign res.source_vertex = rec_q.source_vertex;
	assign res.vertex_total  = rec_q.vertex_total;
	assign res.index_total   = rec_q.index_total;
	assign res.empty_mesh    = rec_q.empty_mesh;
	assign res.last_of_run   = rec_q.last_of_run;

	a_next_bound: assert property (@(posedge clk) disable iff (!arst_n)
		next_q <= LIMIT_MAX) else $error("vertex counter past limit");

	a_empty_no_vertex: assert property (@(posedge clk) disable iff (!arst_n)
		(emit_q == '0) |-> (next_q == '0)) else $error("vertex mapped without index");

	a_dec_loads: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DEC && slot_free) |=> out_valid_q)
		else $error("corner decision lost its record");

	a_wr_new: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.wr |=> (next_q == $past(next_q) + CNT_W'(1)))
		else $error("map write without new slot");
endmodule

// ===== tb/tb_triangle_index_compactor_core.sv =====
// Self-checking testbench for the triangle index compactor core.
module tb_triangle_index_compactor_core;
	import tic_pkg::*;

	typedef struct packed {
		logic                new_mesh;
		logic [CORNER_W-1:0] corner_a;
		logic [CORNER_W-1:0] corner_b;
		logic [CORNER_W-1:0] corner_c;
		logic                last_triangle;
	} triangle_t;

	logic             clk;
	logic             arst_n;
	logic             cfg_wr_en;
	logic [CNT_W-1:0] cfg_wr_data;

	tic_req_if req_ch();
	tic_res_if res_ch();

	triangle_t pending_tris [$];
	triangle_t offered;
	rec_t      expected_recs [$];
	rec_t      want_rec;

	// compaction state mirrored from the block
	logic [CNT_W-1:0] vcount_cfg;
	logic [15:0]      slot_of [int unsigned];
	logic [CNT_W-1:0] next_slot = '0;
	logic [IDX_W-1:0] index_count = '0;

	int  mismatches = 0;
	bit  idle_on;
	int  src_gap;
	int  sink_gap;
	int  hold_left;
	int  hold_requests;
	int  holds_served;

	triangle_index_compactor_core u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.req         (req_ch.sink),
		.res         (res_ch.source)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#6_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("mismatch %s: got %0h want %0h (at %0t)", what, got, want, $realtime);
		mismatches++;
	endtask

	task automatic check_field(string what, logic [31:0] got, logic [31:0] want);
		if (got !== want)
			report_mismatch(what, got, want);
	endtask

	function automatic void predict_triangle(triangle_t t);
		logic [CORNER_W-1:0] corners [3];
		logic [32:0]         lim;
		logic                keep;
		int                  n_out;
		int                  n_done;
		int                  k;
		logic [15:0]         vtx;
		rec_t                r;
		if (t.new_mesh) begin
			slot_of.delete();
			next_slot   = '0;
			index_count = '0;
		end
		corners[0] = t.corner_a;
		corners[1] = t.corner_b;
		corners[2] = t.corner_c;
		lim = (vcount_cfg > LIMIT_MAX) ? 33'(MAX_VERTICES) : 33'(vcount_cfg);
		keep = (33'(t.corner_a) < lim) && (33'(t.corner_b) < lim) && (33'(t.corner_c) < lim) &&
			(t.corner_a != t.corner_b) && (t.corner_a != t.corner_c) &&
			(t.corner_b != t.corner_c);
		n_out  = (keep ? 3 : 0) + (t.last_triangle ? 1 : 0);
		n_done = 0;
		if (keep) begin
			for (k = 0; k < 3; k++) begin
				r = '0;
				r.record_kind = KIND_CORNER;
				vtx = corners[k][15:0];
				if (!slot_of.exists(vtx)) begin
					slot_of[vtx] = next_slot[15:0];
					next_slot    = next_slot + 1'b1;
					r.new_vertex = 1'b1;
				end
				r.compact_index = slot_of[vtx];
				r.source_vertex = vtx;
				if (index_count != INDEX_SAT)
					index_count = index_count + 1'b1;
				n_done++;
				r.last_of_run = (n_done == n_out);
				expected_recs.insert(expected_recs.size(), r);
			end
		end
		if (t.last_triangle) begin
			r = '0;
			r.record_kind  = KIND_SUMMARY;
			r.vertex_total = next_slot;
			r.index_total  = index_count;
			r.empty_mesh   = (index_count == '0);
			r.last_of_run  = 1'b1;
			expected_recs.insert(expected_recs.size(), r);
		end
	endfunction

	function automatic triangle_t random_triangle(logic [CNT_W-1:0] vc);
		triangle_t   t;
		int unsigned lim;
		int unsigned span;
		int unsigned base;
		lim = (vc > LIMIT_MAX) ? MAX_VERTICES : vc;
		t.new_mesh      = ($urandom_range(0, 24) == 0);
		t.last_triangle = ($urandom_range(0, 7) == 0);
		if (lim >= 3 && $urandom_range(0, 9) < 7) begin
			// narrow window most of the time so vertices get reused
			span = ($urandom_range(0, 3) == 0 || lim < 48) ? lim : 48;
			base = $urandom_range(0, lim - span);
			t.corner_a = base + $urandom_range(0, span - 1);
			do t.corner_b = base + $urandom_range(0, span - 1);
			while (t.corner_b == t.corner_a);
			do t.corner_c = base + $urandom_range(0, span - 1);
			while (t.corner_c == t.corner_a || t.corner_c == t.corner_b);
		end else begin
			t.corner_a = $urandom;
			t.corner_b = $urandom;
			t.corner_c = $urandom;
			case ($urandom_range(0, 3))
				1: begin
					t.corner_a = $urandom % (lim + 1);
					t.corner_b = t.corner_a;
					t.corner_c = t.corner_a ^ 32'd1;
				end
				2: begin
					t.corner_a = lim;
					t.corner_b = $urandom % (lim + 1);
					t.corner_c = (lim == 0) ? 0 : lim - 1;
				end
				3: begin
					t.corner_a = (lim == 0) ? 0 : lim - 1;
					t.corner_b = $urandom % (lim + 1);
					t.corner_c = $urandom % (lim + 1);
				end
				default: ;
			endcase
		end
		return t;
	endfunction

	task automatic queue_triangle(logic nm, logic [31:0] a, logic [31:0] b, logic [31:0] c,
		logic last);
		triangle_t t;
		t.new_mesh      = nm;
		t.corner_a      = a;
		t.corner_b      = b;
		t.corner_c      = c;
		t.last_triangle = last;
		pending_tris.insert(pending_tris.size(), t);
	endtask

	// wait until every request is taken and every record has come back
	task automatic drain();
		@(posedge clk);
		@(negedge clk);
		while (pending_tris.size() != 0 || req_ch.valid || expected_recs.size() != 0)
			@(negedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic set_vertex_count(logic [CNT_W-1:0] v);
		@(posedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en   <= 1'b0;
		vcount_cfg = v;
	endtask

	// request driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_ch.valid         <= 1'b0;
			req_ch.new_mesh      <= 1'b0;
			req_ch.corner_a      <= '0;
			req_ch.corner_b      <= '0;
			req_ch.corner_c      <= '0;
			req_ch.last_triangle <= 1'b0;
			src_gap <= 0;
		end else begin
			if (req_ch.valid && req_ch.ready)
				predict_triangle(offered);
			if (!req_ch.valid || req_ch.ready) begin
				if (src_gap > 0) begin
					src_gap      <= src_gap - 1;
					req_ch.valid <= 1'b0;
				end else if (pending_tris.size() != 0 && idle_on && $urandom_range(0, 5) == 0) begin
					src_gap      <= $urandom_range(0, 8);
					req_ch.valid <= 1'b0;
				end else if (pending_tris.size() != 0) begin
					offered = pending_tris.pop_front();
					req_ch.new_mesh      <= offered.new_mesh;
					req_ch.corner_a      <= offered.corner_a;
					req_ch.corner_b      <= offered.corner_b;
					req_ch.corner_c      <= offered.corner_c;
					req_ch.last_triangle <= offered.last_triangle;
					req_ch.valid         <= 1'b1;
				end else begin
					req_ch.valid <= 1'b0;
				end
			end
		end
	end

	// result ready: random stalls plus requested long hold-offs
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_ch.ready <= 1'b0;
			sink_gap     <= 0;
			hold_left    <= 0;
			holds_served <= 0;
		end else if (holds_served != hold_requests) begin
			holds_served <= holds_served + 1;
			hold_left    <= 90;
			res_ch.ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left    <= hold_left - 1;
			res_ch.ready <= 1'b0;
		end else if (sink_gap > 0) begin
			sink_gap     <= sink_gap - 1;
			res_ch.ready <= 1'b0;
		end else if (idle_on && $urandom_range(0, 7) == 0) begin
			sink_gap     <= $urandom_range(0, 8);
			res_ch.ready <= 1'b0;
		end else begin
			res_ch.ready <= 1'b1;
		end
	end

	// result monitor
	always @(posedge clk) begin
		if (arst_n && res_ch.valid && res_ch.ready) begin
			if (expected_recs.size() == 0) begin
				report_mismatch("record with nothing expected", 32'(res_ch.record_kind), 32'd0);
			end else begin
				want_rec = expected_recs.pop_front();
				check_field("record_kind", 32'(res_ch.record_kind),
					32'(want_rec.record_kind));
				check_field("compact_index", 32'(res_ch.compact_index),
					32'(want_rec.compact_index));
				check_field("new_vertex", 32'(res_ch.new_vertex), 32'(want_rec.new_vertex));
				check_field("source_vertex", 32'(res_ch.source_vertex),
					32'(want_rec.source_vertex));
				check_field("vertex_total", 32'(res_ch.vertex_total),
					32'(want_rec.vertex_total));
				check_field("index_total", 32'(res_ch.index_total), 32'(want_rec.index_total));
				check_field("empty_mesh", 32'(res_ch.empty_mesh), 32'(want_rec.empty_mesh));
				check_field("last_of_run", 32'(res_ch.last_of_run), 32'(want_rec.last_of_run));
			end
		end
	end

	initial begin
		int unsigned phase_vc [10];
		int          phase_len [10];
		int          p;
		int          i;
		arst_n        = 1'b0;
		cfg_wr_en     = 1'b0;
		cfg_wr_data   = '0;
		hold_requests = 0;
		idle_on       = 1'b1;
		vcount_cfg    = LIMIT_MAX;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// reset limit: empty mesh, extremes, reuse, drops of every kind
		queue_triangle(1'b1, 0, 0, 0, 1'b1);
		queue_triangle(1'b0, 0, 1, 2, 1'b0);
		queue_triangle(1'b0, 65535, 0, 1, 1'b0);
		queue_triangle(1'b0, 65536, 1, 2, 1'b0);
		queue_triangle(1'b0, 32'hFFFF_FFFF, 3, 4, 1'b1);
		queue_triangle(1'b0, 5, 5, 6, 1'b0);
		queue_triangle(1'b0, 5, 6, 5, 1'b0);
		queue_triangle(1'b0, 6, 5, 5, 1'b0);
		queue_triangle(1'b0, 32'h8000_0000, 32'h7FFF_FFFF, 1, 1'b0);
		queue_triangle(1'b0, 2, 1, 0, 1'b1);
		queue_triangle(1'b0, 0, 1, 65534, 1'b1);
		queue_triangle(1'b1, 7, 8, 9, 1'b1);
		queue_triangle(1'b1, 7, 8, 8, 1'b1);
		drain();

		set_vertex_count(CNT_W'(3));
		queue_triangle(1'b1, 0, 1, 2, 1'b1);
		queue_triangle(1'b0, 0, 1, 3, 1'b0);
		queue_triangle(1'b0, 2, 1, 0, 1'b1);
		drain();

		set_vertex_count(CNT_W'(0));
		queue_triangle(1'b1, 0, 1, 2, 1'b1);
		drain();

		set_vertex_count(17'h1FFFF);
		queue_triangle(1'b1, 65535, 65534, 0, 1'b0);
		queue_triangle(1'b0, 65536, 0, 1, 1'b1);
		drain();

		phase_vc  = '{65536, 48, 131071, 1, 16, 0, 65537, 200, 0, 65536};
		phase_len = '{60, 50, 40, 12, 50, 50, 30, 50, 10, 60};
		phase_vc[5] = $urandom_range(3, 65536);
		for (p = 0; p < 10; p++) begin
			set_vertex_count(CNT_W'(phase_vc[p]));
			if (p == 0)
				hold_requests = hold_requests + 1;
			if (p == 9)
				idle_on = 1'b0;
			for (i = 0; i < phase_len[p]; i++)
				pending_tris.insert(pending_tris.size(),
					random_triangle(CNT_W'(phase_vc[p])));
			drain();
		end

		if (mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

// ===== filelist.f =====
src/tic_pkg.sv
src/tic_req_if.sv
src/tic_res_if.sv
src/tic_map_store.sv
src/triangle_index_compactor_core.sv
tb/tb_triangle_index_compactor_core.sv
